/* design/assert_macros.svh */
// Assertion macros used by the back end RTL (cohm_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* design/cohm_pkg.sv */
// Package: types, constants and contribution tables of the cohesion block
`timescale 1ns / 1ps
package cohm_pkg;
   localparam int MAX_POINTS = 16;
   localparam int DIST_BITS  = 16;
   localparam int FRAC_BITS  = 24;
   localparam int IDX_BITS   = 4;
   localparam int ADDR_BITS  = 2 * IDX_BITS;
   localparam int DEPTH      = MAX_POINTS * MAX_POINTS;
   localparam int NUM_BITS   = 5;
   localparam int COH_BITS   = 28;
   localparam int ADD_BITS   = FRAC_BITS + 1;
   localparam int SIZE_BITS  = 5;
   localparam int BETA_BITS  = 16;
   localparam int LIM_BITS   = BETA_BITS + DIST_BITS;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_COMPUTE = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;
   localparam logic [1:0] CMD_NOP     = 2'd3;

   localparam logic REG_BETA   = 1'b0;
   localparam logic REG_POINTS = 1'b1;

   localparam logic [BETA_BITS-1:0] BETA_RESET   = 16'd4096;
   localparam logic [NUM_BITS-1:0]  POINTS_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [IDX_BITS-1:0]  row;
      logic [IDX_BITS-1:0]  col;
      logic [DIST_BITS-1:0] distance;
      logic                 err;
   } entry_type;

   // floor(2^24 / size)
   function automatic logic [ADD_BITS-1:0] whole_share(input logic [SIZE_BITS-1:0] size);
      logic [ADD_BITS-1:0] v;
      case (size)
         5'd1:  v = 25'd16777216;
         5'd2:  v = 25'd8388608;
         5'd3:  v = 25'd5592405;
         5'd4:  v = 25'd4194304;
         5'd5:  v = 25'd3355443;
         5'd6:  v = 25'd2796202;
         5'd7:  v = 25'd2396745;
         5'd8:  v = 25'd2097152;
         5'd9:  v = 25'd1864135;
         5'd10: v = 25'd1677721;
         5'd11: v = 25'd1525201;
         5'd12: v = 25'd1398101;
         5'd13: v = 25'd1290555;
         5'd14: v = 25'd1198372;
         5'd15: v = 25'd1118481;
         5'd16: v = 25'd1048576;
         default: v = '0;
      endcase
      return v;
   endfunction

   // floor(2^23 / size)
   function automatic logic [ADD_BITS-1:0] half_share(input logic [SIZE_BITS-1:0] size);
      logic [ADD_BITS-1:0] v;
      case (size)
         5'd1:  v = 25'd8388608;
         5'd2:  v = 25'd4194304;
         5'd3:  v = 25'd2796202;
         5'd4:  v = 25'd2097152;
         5'd5:  v = 25'd1677721;
         5'd6:  v = 25'd1398101;
         5'd7:  v = 25'd1198372;
         5'd8:  v = 25'd1048576;
         5'd9:  v = 25'd932067;
         5'd10: v = 25'd838860;
         5'd11: v = 25'd762600;
         5'd12: v = 25'd699050;
         5'd13: v = 25'd645277;
         5'd14: v = 25'd599186;
         5'd15: v = 25'd559240;
         5'd16: v = 25'd524288;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

/* design/cohm_if.sv */
// Channel interfaces: request, response and register write
`timescale 1ns / 1ps
interface cohm_req_if import cohm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           cmd;
   logic [IDX_BITS-1:0]  row_index;
   logic [IDX_BITS-1:0]  col_index;
   logic [15:0]          distance;
   modport source (output valid, cmd, row_index, col_index, distance, input ready);
   modport sink   (input valid, cmd, row_index, col_index, distance, output ready);
endinterface

interface cohm_rsp_if import cohm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COH_BITS-1:0] cohesion;
   logic                index_error;
   modport source (output valid, cohesion, index_error, input ready);
   modport sink   (input valid, cohesion, index_error, output ready);
endinterface

interface cohm_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/local_depth_cohesion_matrix_top.sv */
// Top level of the partitioned local depth cohesion matrix block
`timescale 1ns / 1ps
// A load beat is handled in the idle state; a read beat waits in ST_RD_WAIT
// on the registered cohesion store read. A compute beat walks every pair x<y
// of the n active points with two passes over z, count then accumulate; each
// cohesion update goes through ST_COH_WR and the single cohesion write port,
// and a tie writes both the x-z and y-z entries. The front accepts up to two
// beats into its queue while the back works.
// The cohesion store clears at once through per-entry valid bits.
module local_depth_cohesion_matrix_top import cohm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   cohm_req_if.sink    req_chan,
   cohm_rsp_if.source  rsp_chan,
   cohm_csr_if.sink    csr_chan
);
   logic [BETA_BITS-1:0] beta_ff;
   logic [NUM_BITS-1:0]  points_ff;
   logic [NUM_BITS-1:0]  num_points;
   logic                 push, full, pop, head_valid;
   entry_type            push_entry, head_entry;

   assign csr_chan.ready = 1'b1;
   assign num_points = (points_ff > NUM_BITS'(MAX_POINTS)) ? NUM_BITS'(MAX_POINTS) : points_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff   <= BETA_RESET;
         points_ff <= POINTS_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_BETA:   beta_ff   <= csr_chan.data;
            REG_POINTS: points_ff <= csr_chan.data[NUM_BITS-1:0];
            default: ;
         endcase
      end
   end

   cohm_front u_front (
      .req_chan   (req_chan),
      .num_points (num_points),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   cohm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   cohm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (head_valid),
      .q_entry    (head_entry),
      .q_pop      (pop),
      .beta       (beta_ff),
      .num_points (num_points),
      .rsp_chan   (rsp_chan)
   );
endmodule

/* design/cohm_queue.sv */
// Two-entry queue between front and back
`timescale 1ns / 1ps
module cohm_queue import cohm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);
   entry_type   slot_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

/* design/cohm_front.sv */
// Front: accepts request beats, checks indices, pushes into the queue
`timescale 1ns / 1ps
module cohm_front import cohm_pkg::*; (
   cohm_req_if.sink             req_chan,
   input  logic [NUM_BITS-1:0]  num_points,
   input  logic                 queue_full,
   output logic                 push,
   output entry_type            push_entry
);
   logic row_bad, col_bad, needs_index;

   assign req_chan.ready = ~queue_full;
   assign push           = req_chan.valid & ~queue_full;

   assign row_bad     = {1'b0, req_chan.row_index} >= num_points;
   assign col_bad     = {1'b0, req_chan.col_index} >= num_points;
   assign needs_index = (req_chan.cmd == CMD_LOAD) || (req_chan.cmd == CMD_READ);

   always_comb begin
      push_entry.cmd      = req_chan.cmd;
      push_entry.row      = req_chan.row_index;
      push_entry.col      = req_chan.col_index;
      push_entry.distance = req_chan.distance[DIST_BITS-1:0];
      push_entry.err      = needs_index & (row_bad | col_bad);
   end
endmodule

/* design/cohm_back.sv */
// Back: distance and cohesion stores, compute sequencer, response register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cohm_back import cohm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  entry_type            q_entry,
   output logic                 q_pop,
   input  logic [BETA_BITS-1:0] beta,
   input  logic [NUM_BITS-1:0]  num_points,
   cohm_rsp_if.source           rsp_chan
);
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_RD_WAIT  = 4'd1;
   localparam logic [3:0] ST_PAIR_RD  = 4'd2;
   localparam logic [3:0] ST_PAIR_MUL = 4'd3;
   localparam logic [3:0] ST_CNT_RD   = 4'd4;
   localparam logic [3:0] ST_CNT_EV   = 4'd5;
   localparam logic [3:0] ST_ACC_RD   = 4'd6;
   localparam logic [3:0] ST_ACC_EV   = 4'd7;
   localparam logic [3:0] ST_COH_WR   = 4'd8;
   localparam logic [3:0] ST_NEXT     = 4'd9;

   logic [DIST_BITS-1:0] dist_mem [DEPTH];
   logic [COH_BITS-1:0]  coh_mem  [DEPTH];
   logic [DEPTH-1:0]     coh_vld_ff;

   logic [3:0]           state_ff, state_in;
   logic [IDX_BITS-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [LIM_BITS-1:0]  lim_ff, lim_in;
   logic [ADDR_BITS-1:0] tgt_ff, tgt_in;
   logic [ADD_BITS-1:0]  add_ff, add_in;
   logic                 tie_ff, tie_in;

   logic                 rsp_valid_ff;
   logic [COH_BITS-1:0]  rsp_coh_ff;
   logic                 rsp_err_ff;

   logic [DIST_BITS-1:0] da_q_ff, db_q_ff;
   logic [COH_BITS-1:0]  coh_q_ff;
   logic                 coh_qv_ff;

   logic                 d_we, d_rd_en, c_rd_en, c_we, clr_all;
   logic [ADDR_BITS-1:0] da_addr, db_addr, c_rd_addr;
   logic [COH_BITS-1:0]  c_wdata;
   logic                 rsp_load, rsp_err_val;
   logic [COH_BITS-1:0]  rsp_coh_val;

   logic                 focus, last_z, slot_free;
   logic [SIZE_BITS-1:0] size_nx;
   logic [COH_BITS-1:0]  old_val;
   logic [COH_BITS:0]    sum;

   assign focus = ({{(LIM_BITS-DIST_BITS-12){1'b0}}, da_q_ff, 12'd0} <= lim_ff) ||
                  ({{(LIM_BITS-DIST_BITS-12){1'b0}}, db_q_ff, 12'd0} <= lim_ff);
   assign last_z    = ({1'b0, z_ff} == num_points - 5'd1);
   assign size_nx   = size_ff + SIZE_BITS'(focus);
   assign slot_free = ~rsp_valid_ff | rsp_chan.ready;
   assign old_val   = coh_qv_ff ? coh_q_ff : '0;
   assign sum       = {1'b0, old_val} + (COH_BITS+1)'(add_ff);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff;
      size_in = size_ff; lim_in = lim_ff; tgt_in = tgt_ff; add_in = add_ff; tie_in = tie_ff;
      q_pop = 1'b0; d_we = 1'b0; d_rd_en = 1'b0; c_rd_en = 1'b0; c_we = 1'b0;
      clr_all = 1'b0;
      da_addr = {x_ff, y_ff}; db_addr = {z_ff, y_ff}; c_rd_addr = tgt_ff;
      c_wdata = sum[COH_BITS] ? {COH_BITS{1'b1}} : sum[COH_BITS-1:0];
      rsp_load = 1'b0; rsp_err_val = 1'b0; rsp_coh_val = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid && slot_free) begin
               q_pop = 1'b1;
               case (q_entry.cmd)
                  CMD_LOAD: begin
                     d_we        = ~q_entry.err;
                     rsp_load    = 1'b1;
                     rsp_err_val = q_entry.err;
                  end
                  CMD_READ: begin
                     if (q_entry.err) begin
                        rsp_load    = 1'b1;
                        rsp_err_val = 1'b1;
                     end else begin
                        c_rd_en   = 1'b1;
                        c_rd_addr = {q_entry.row, q_entry.col};
                        state_in  = ST_RD_WAIT;
                     end
                  end
                  CMD_COMPUTE: begin
                     clr_all = 1'b1;
                     if (num_points < 5'd2) begin
                        rsp_load = 1'b1;
                     end else begin
                        x_in     = '0;
                        y_in     = IDX_BITS'(1);
                        state_in = ST_PAIR_RD;
                     end
                  end
                  default: rsp_load = 1'b1;
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_load    = 1'b1;
            rsp_coh_val = old_val;
            state_in    = ST_IDLE;
         end
         ST_PAIR_RD: begin
            d_rd_en  = 1'b1;
            da_addr  = {x_ff, y_ff};
            state_in = ST_PAIR_MUL;
         end
         ST_PAIR_MUL: begin
            lim_in   = LIM_BITS'(beta) * LIM_BITS'(da_q_ff);
            z_in     = '0;
            size_in  = '0;
            state_in = ST_CNT_RD;
         end
         ST_CNT_RD, ST_ACC_RD: begin
            d_rd_en  = 1'b1;
            da_addr  = {z_ff, x_ff};
            db_addr  = {z_ff, y_ff};
            state_in = (state_ff == ST_CNT_RD) ? ST_CNT_EV : ST_ACC_EV;
         end
         ST_CNT_EV: begin
            size_in = size_nx;
            if (last_z) begin
               z_in     = '0;
               state_in = (size_nx != '0) ? ST_ACC_RD : ST_NEXT;
            end else begin
               z_in     = z_ff + IDX_BITS'(1);
               state_in = ST_CNT_RD;
            end
         end
         ST_ACC_EV: begin
            if (!focus) begin
               z_in     = z_ff + IDX_BITS'(1);
               state_in = last_z ? ST_NEXT : ST_ACC_RD;
            end else begin
               c_rd_en = 1'b1;
               if (da_q_ff < db_q_ff) begin
                  tgt_in = {x_ff, z_ff}; add_in = whole_share(size_ff); tie_in = 1'b0;
               end else if (db_q_ff < da_q_ff) begin
                  tgt_in = {y_ff, z_ff}; add_in = whole_share(size_ff); tie_in = 1'b0;
               end else begin
                  tgt_in = {x_ff, z_ff}; add_in = half_share(size_ff); tie_in = 1'b1;
               end
               c_rd_addr = tgt_in;
               state_in  = ST_COH_WR;
            end
         end
         ST_COH_WR: begin
            c_we = 1'b1;
            if (tie_ff) begin
               tie_in    = 1'b0;
               tgt_in    = {y_ff, z_ff};
               c_rd_en   = 1'b1;
               c_rd_addr = {y_ff, z_ff};
            end else begin
               z_in     = z_ff + IDX_BITS'(1);
               state_in = last_z ? ST_NEXT : ST_ACC_RD;
            end
         end
         ST_NEXT: begin
            if (({1'b0, y_ff} + 5'd1) < num_points) begin
               y_in     = y_ff + IDX_BITS'(1);
               state_in = ST_PAIR_RD;
            end else if (({1'b0, x_ff} + 5'd2) < num_points) begin
               x_in     = x_ff + IDX_BITS'(1);
               y_in     = x_ff + IDX_BITS'(2);
               state_in = ST_PAIR_RD;
            end else begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // distance store: one write port, two read ports
   always_ff @(posedge clock) begin
      if (d_we) begin
         dist_mem[{q_entry.row, q_entry.col}] <= q_entry.distance;
      end
      if (d_rd_en) begin
         da_q_ff <= dist_mem[da_addr];
         db_q_ff <= dist_mem[db_addr];
      end
   end

   // cohesion store: one write port, one read port
   always_ff @(posedge clock) begin
      if (c_we) begin
         coh_mem[tgt_ff] <= c_wdata;
      end
      if (c_rd_en) begin
         coh_q_ff  <= coh_mem[c_rd_addr];
         coh_qv_ff <= coh_vld_ff[c_rd_addr] & ~(c_we & (c_rd_addr == tgt_ff));
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      size_ff <= size_in; lim_ff <= lim_in; tgt_ff <= tgt_in;
      add_ff <= add_in; tie_ff <= tie_in;
      if (rsp_load) begin
         rsp_coh_ff <= rsp_coh_val;
         rsp_err_ff <= rsp_err_val;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         coh_vld_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (clr_all) begin
            coh_vld_ff <= '0;
         end else if (c_we) begin
            coh_vld_ff[tgt_ff] <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cohesion    = rsp_coh_ff;
   assign rsp_chan.index_error = rsp_err_ff;

   `ASSERT_SAME(a_pop_only_idle, q_pop, state_ff == ST_IDLE)
   `ASSERT_SAME(a_err_no_data, rsp_valid_ff && rsp_err_ff, rsp_coh_ff == '0)
   `ASSERT_SAME(a_write_in_range, c_we, ({1'b0, z_ff} < num_points) && (x_ff < y_ff))
endmodule
